// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SAABB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("saabb check failed");

// Check a property on every clock edge, reset included.
`define SAABB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("saabb check failed");

`endif

// File: sv/saabb_pkg.sv
// ----------------------------------------------------------------------------
// saabb_pkg
// Shared types and constants for the swept box collision-time block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package saabb_pkg;

    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // Per-axis side flags that ride along the divider pipeline
    typedef struct packed {
        logic zero;   // displacement on this axis is zero
        logic ovl;    // boxes overlap on this axis
    } axis_flag_t;

endpackage

// File: sv/saabb_ifs.sv
// ----------------------------------------------------------------------------
// saabb interfaces
// Valid/ready channels for moving boxes, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface saabb_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] mov_min_x;
    logic signed [COORD_WIDTH-1:0] mov_min_y;
    logic signed [COORD_WIDTH-1:0] mov_min_z;
    logic signed [COORD_WIDTH-1:0] mov_max_x;
    logic signed [COORD_WIDTH-1:0] mov_max_y;
    logic signed [COORD_WIDTH-1:0] mov_max_z;
    logic signed [COORD_WIDTH-1:0] delta_x;
    logic signed [COORD_WIDTH-1:0] delta_y;
    logic signed [COORD_WIDTH-1:0] delta_z;
    modport source (output valid, mov_min_x, mov_min_y, mov_min_z, mov_max_x,
                    mov_max_y, mov_max_z, delta_x, delta_y, delta_z, input ready);
    modport sink (input valid, mov_min_x, mov_min_y, mov_min_z, mov_max_x,
                  mov_max_y, mov_max_z, delta_x, delta_y, delta_z, output ready);
endinterface

interface saabb_out_if #(parameter int TIME_FRAC_BITS = 16);
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [TIME_FRAC_BITS:0]   t_enter;
    modport source (output valid, hit, t_enter, input ready);
    modport sink (input valid, hit, t_enter, output ready);
endinterface

interface saabb_cfg_if #(parameter int COORD_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [2:0]             index;
    logic [COORD_WIDTH-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/swept_aabb_collision_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_aabb_collision_time
// Swept box against stationary box, first contact time by the slab method.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : write the stationary box, index 0..5 = min x,y,z then max x,y,z.
//            Always ready; write only while no item is in flight.
//   in_ch  : one moving box plus its displacement per transfer.
//   out_ch : one result per input, in order: hit flag and entry time in
//            unsigned Q1.TIME_FRAC_BITS (0 when no hit).
// Throughput: one item per cycle while the output is ready. Six dividers
// (entry and leave gap per axis) each resolve one quotient bit per stage.
// Pipeline: TIME_FRAC_BITS + 3 register stages (gap stage, TIME_FRAC_BITS + 1
//   divider stages, merge/output stage).
// Reset: the pipeline empties and the stationary box clears to zero.
// Stall: each stage holds while the one ahead is full and stalled; bubbles
//   collapse, so input is still taken while a result waits on the output as
//   long as some stage is empty.
// ----------------------------------------------------------------------------

module swept_aabb_collision_time
    import saabb_pkg::*;
#(
    parameter int COORD_WIDTH    = 32,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    saabb_in_if.sink    in_ch,
    saabb_out_if.source out_ch,
    saabb_cfg_if.sink   cfg
);

    localparam int NST = TIME_FRAC_BITS + 3;
    localparam int NDV = TIME_FRAC_BITS + 1;
    localparam int QW  = TIME_FRAC_BITS + 2;

    logic [COORD_WIDTH-1:0] smin_reg [NUM_AXES];
    logic [COORD_WIDTH-1:0] smax_reg [NUM_AXES];

    logic [NST-1:0] valid_reg;
    logic [NST:0]   rdy;

    // Take configuration writes
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                smin_reg[i] <= '0;
                smax_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_X: smin_reg[0] <= cfg.data;
                REG_MIN_Y: smin_reg[1] <= cfg.data;
                REG_MIN_Z: smin_reg[2] <= cfg.data;
                REG_MAX_X: smax_reg[0] <= cfg.data;
                REG_MAX_Y: smax_reg[1] <= cfg.data;
                REG_MAX_Z: smax_reg[2] <= cfg.data;
                default: ;
            endcase
        end
    end

    // Per-stage ready: advance into a stage that is empty or draining
    always_comb
    begin
        rdy[NST] = out_ch.ready;
        for (int i = NST - 1; i >= 0; i--)
            rdy[i] = !valid_reg[i] || rdy[i+1];
    end
    assign in_ch.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NST; i++)
                if (rdy[i])
                    valid_reg[i] <= (i == 0) ? in_ch.valid : valid_reg[i-1];
        end
    end

    // Gap stage and dividers per axis
    logic signed [COORD_WIDTH-1:0] mmin [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] mmax [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] dlt  [NUM_AXES];
    logic [COORD_WIDTH:0]   f_en_mag [NUM_AXES];
    logic [COORD_WIDTH:0]   f_lv_mag [NUM_AXES];
    logic                   f_en_neg [NUM_AXES];
    logic                   f_lv_neg [NUM_AXES];
    logic [COORD_WIDTH-1:0] f_d_mag  [NUM_AXES];
    axis_flag_t             f_flag   [NUM_AXES];
    logic [QW-1:0]          q_en_mag [NUM_AXES];
    logic [QW-1:0]          q_lv_mag [NUM_AXES];
    logic                   q_en_neg [NUM_AXES];
    logic                   q_lv_neg [NUM_AXES];
    axis_flag_t             flag_reg [NUM_AXES][NDV];
    axis_flag_t             q_flag   [NUM_AXES];

    assign mmin[0] = in_ch.mov_min_x;
    assign mmin[1] = in_ch.mov_min_y;
    assign mmin[2] = in_ch.mov_min_z;
    assign mmax[0] = in_ch.mov_max_x;
    assign mmax[1] = in_ch.mov_max_y;
    assign mmax[2] = in_ch.mov_max_z;
    assign dlt[0]  = in_ch.delta_x;
    assign dlt[1]  = in_ch.delta_y;
    assign dlt[2]  = in_ch.delta_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        saabb_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
            .clk    (clk),
            .en     (rdy[0]),
            .smin   (smin_reg[a]),
            .smax   (smax_reg[a]),
            .mmin   (mmin[a]),
            .mmax   (mmax[a]),
            .dlt    (dlt[a]),
            .en_mag (f_en_mag[a]),
            .lv_mag (f_lv_mag[a]),
            .en_neg (f_en_neg[a]),
            .lv_neg (f_lv_neg[a]),
            .d_mag  (f_d_mag[a]),
            .flag   (f_flag[a])
        );

        saabb_div #(.COORD_WIDTH(COORD_WIDTH), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_en (
            .clk     (clk),
            .en      (rdy[NDV:1]),
            .num     (f_en_mag[a]),
            .den     (f_d_mag[a]),
            .neg_in  (f_en_neg[a]),
            .mag     (q_en_mag[a]),
            .neg_out (q_en_neg[a])
        );

        saabb_div #(.COORD_WIDTH(COORD_WIDTH), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_lv (
            .clk     (clk),
            .en      (rdy[NDV:1]),
            .num     (f_lv_mag[a]),
            .den     (f_d_mag[a]),
            .neg_in  (f_lv_neg[a]),
            .mag     (q_lv_mag[a]),
            .neg_out (q_lv_neg[a])
        );

        // Carry axis flags alongside the divider stages
        always_ff @(posedge clk)
        begin
            for (int k = 0; k < NDV; k++)
                if (rdy[k+1])
                    flag_reg[a][k] <= (k == 0) ? f_flag[a] : flag_reg[a][k-1];
        end
        assign q_flag[a] = flag_reg[a][NDV-1];
    end

    // Merge and register the result
    logic                    m_hit, hit_reg;
    logic [TIME_FRAC_BITS:0] m_t, t_reg;

    saabb_merge #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_merge (
        .en_mag  (q_en_mag),
        .lv_mag  (q_lv_mag),
        .en_neg  (q_en_neg),
        .lv_neg  (q_lv_neg),
        .flag    (q_flag),
        .hit     (m_hit),
        .t_enter (m_t)
    );

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
        begin
            hit_reg <= m_hit;
            t_reg   <= m_t;
        end
    end

    assign out_ch.valid   = valid_reg[NST-1];
    assign out_ch.hit     = hit_reg;
    assign out_ch.t_enter = t_reg;

endmodule

// File: sv/saabb_front.sv
// ----------------------------------------------------------------------------
// saabb_front
// One axis: form entry and leave gaps, their magnitudes and signs, register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saabb_front
    import saabb_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] smin,
    input  logic signed [COORD_WIDTH-1:0] smax,
    input  logic signed [COORD_WIDTH-1:0] mmin,
    input  logic signed [COORD_WIDTH-1:0] mmax,
    input  logic signed [COORD_WIDTH-1:0] dlt,
    output logic [COORD_WIDTH:0]          en_mag,
    output logic [COORD_WIDTH:0]          lv_mag,
    output logic                          en_neg,
    output logic                          lv_neg,
    output logic [COORD_WIDTH-1:0]        d_mag,
    output axis_flag_t                    flag
);

    localparam int GW = COORD_WIDTH + 1;

    logic signed [GW-1:0] gap_en, gap_lv, dlt_ext;
    logic [GW-1:0]        en_mag_next, lv_mag_next, d_abs;
    logic [GW-1:0]        en_mag_reg, lv_mag_reg;
    logic [COORD_WIDTH-1:0] d_mag_reg;
    logic                 en_neg_reg, lv_neg_reg;
    axis_flag_t           flag_next, flag_reg;

    // Form gaps and magnitudes
    always_comb
    begin
        gap_en      = GW'(smin) - GW'(mmax);
        gap_lv      = GW'(smax) - GW'(mmin);
        dlt_ext     = GW'(dlt);
        en_mag_next = gap_en[GW-1] ? GW'(-gap_en) : GW'(gap_en);
        lv_mag_next = gap_lv[GW-1] ? GW'(-gap_lv) : GW'(gap_lv);
        d_abs       = dlt_ext[GW-1] ? GW'(-dlt_ext) : GW'(dlt_ext);
        flag_next.zero = (dlt == '0);
        flag_next.ovl  = !(smin > mmax || smax < mmin);
    end

    // Hold stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            en_mag_reg <= en_mag_next;
            lv_mag_reg <= lv_mag_next;
            d_mag_reg  <= d_abs[COORD_WIDTH-1:0];
            en_neg_reg <= gap_en[GW-1] ^ dlt[COORD_WIDTH-1];
            lv_neg_reg <= gap_lv[GW-1] ^ dlt[COORD_WIDTH-1];
            flag_reg   <= flag_next;
        end
    end

    assign en_mag = en_mag_reg;
    assign lv_mag = lv_mag_reg;
    assign d_mag  = d_mag_reg;
    assign en_neg = en_neg_reg;
    assign lv_neg = lv_neg_reg;
    assign flag   = flag_reg;

endmodule

// File: sv/saabb_div.sv
// ----------------------------------------------------------------------------
// saabb_div
// Pipelined restoring divider: num * 2^TFB / den, one quotient bit a stage,
// saturated at 2.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saabb_div #(
    parameter int COORD_WIDTH    = 32,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic [TIME_FRAC_BITS:0]   en,
    input  logic [COORD_WIDTH:0]      num,
    input  logic [COORD_WIDTH-1:0]    den,
    input  logic                      neg_in,
    output logic [TIME_FRAC_BITS+1:0] mag,
    output logic                      neg_out
);

    localparam int GW  = COORD_WIDTH + 1;
    localparam int QW  = TIME_FRAC_BITS + 2;
    localparam int NST = TIME_FRAC_BITS + 1;
    localparam logic [QW-1:0] T_LIM = QW'(1) << (TIME_FRAC_BITS + 1);

    logic [GW-1:0]          r_reg [NST];
    logic [QW-1:0]          q_reg [NST];
    logic [COORD_WIDTH-1:0] d_reg [NST];
    logic                   sat_reg [NST];
    logic                   neg_reg [NST];

    logic [GW-1:0] den_ext, den2;
    logic          ge1;

    always_comb
    begin
        den_ext = GW'(den);
        den2    = {den, 1'b0};
        ge1     = (num >= den_ext);
    end

    // First stage: saturation check and integer bit
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat_reg[0] <= (num >= den2);
            q_reg[0]   <= QW'(ge1);
            r_reg[0]   <= ge1 ? (num - den_ext) : num;
            d_reg[0]   <= den;
            neg_reg[0] <= neg_in;
        end
    end

    // Fraction stages: one shift-compare-subtract each
    for (genvar k = 1; k < NST; k++)
    begin : g_step
        logic [GW-1:0] rs;
        logic          take;
        always_comb
        begin
            rs   = {r_reg[k-1][GW-2:0], 1'b0};
            take = (rs >= GW'(d_reg[k-1]));
        end
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                r_reg[k]   <= take ? (rs - GW'(d_reg[k-1])) : rs;
                q_reg[k]   <= {q_reg[k-1][QW-2:0], take};
                d_reg[k]   <= d_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign mag     = sat_reg[NST-1] ? T_LIM : q_reg[NST-1];
    assign neg_out = neg_reg[NST-1];

endmodule

// File: sv/saabb_merge.sv
// ----------------------------------------------------------------------------
// saabb_merge
// Sign, order and intersect the per-axis times into a hit flag and entry time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saabb_merge
    import saabb_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic [TIME_FRAC_BITS+1:0] en_mag [NUM_AXES],
    input  logic [TIME_FRAC_BITS+1:0] lv_mag [NUM_AXES],
    input  logic                      en_neg [NUM_AXES],
    input  logic                      lv_neg [NUM_AXES],
    input  axis_flag_t                flag   [NUM_AXES],
    output logic                      hit,
    output logic [TIME_FRAC_BITS:0]   t_enter
);

    localparam int TW = TIME_FRAC_BITS + 3;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << TIME_FRAC_BITS;

    logic signed [TW-1:0] te, tl, a, b, lo, hi;
    logic                 ok;

    // Intersect the running interval axis by axis
    always_comb
    begin
        te = '0;
        tl = T_ONE;
        ok = 1'b1;
        a  = '0;
        b  = '0;
        lo = '0;
        hi = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a  = en_neg[i] ? -TW'(en_mag[i]) : TW'(en_mag[i]);
            b  = lv_neg[i] ? -TW'(lv_mag[i]) : TW'(lv_mag[i]);
            lo = (a > b) ? b : a;
            hi = (a > b) ? a : b;
            if (flag[i].zero)
            begin
                ok = ok & flag[i].ovl;
            end
            else
            begin
                if (lo > te)
                    te = lo;
                if (hi < tl)
                    tl = hi;
            end
        end
        ok = ok & !(te > tl);
    end

    assign hit     = ok;
    assign t_enter = ok ? te[TIME_FRAC_BITS:0] : '0;

endmodule

// File: sv/saabb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saabb_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module saabb_chk #(
    parameter int TIME_FRAC_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    out_hit,
    input logic [TIME_FRAC_BITS:0] out_t
);

    localparam logic [TIME_FRAC_BITS:0] T_ONE = (TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS;

    // Hold a stalled result
    `SAABB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_t))
    // Drop the time on a miss
    `SAABB_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_t == '0)
    // Keep the time within the step
    `SAABB_ASSERT(a_t_range, out_valid |-> out_t <= T_ONE)
    // Empty the pipeline once reset has been seen at an edge
    `SAABB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind swept_aabb_collision_time saabb_chk #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_saabb_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hit   (out_ch.hit),
    .out_t     (out_ch.t_enter)
);
